// ===== design/dact_pkg.sv =====
// ----------------------------------------------------------------------------
// dact_pkg
// Shared types and constants of the denied-access counter table.
// ----------------------------------------------------------------------------
package dact_pkg;

  localparam int MAX_USERS_DEF = 32;
  localparam int USER_W        = 32;
  localparam int COUNT_W       = 16;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [COUNT_W-1:0] THRESH_RESET = COUNT_W'(7);

  // register index, taken from paddr[2]
  localparam logic REG_DENIED_THRESHOLD = 1'b0;

  // input action codes
  localparam logic ACT_LOG    = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  typedef struct packed {
    logic               entry_valid;
    logic [USER_W-1:0]  user_out;
    logic [COUNT_W-1:0] denied_count;
    logic               over_threshold;
    logic               table_full;
    logic               last;
  } res_t;

endpackage

// ===== design/dact_ram.sv =====
// ----------------------------------------------------------------------------
// dact_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dact_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/dact_apb.sv =====
// ----------------------------------------------------------------------------
// dact_apb
// APB register slave holding the denied-count threshold.
// ----------------------------------------------------------------------------
module dact_apb import dact_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [COUNT_W-1:0]    threshold
);

  logic [COUNT_W-1:0] thresh_r;
  logic               hit;

  assign hit    = (paddr[2] == REG_DENIED_THRESHOLD);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (psel && penable && pwrite && hit) begin
      thresh_r <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata[COUNT_W-1:0] = thresh_r;
    end
  end

  assign threshold = thresh_r;

endmodule

// ===== design/dact_ctrl.sv =====
// ----------------------------------------------------------------------------
// dact_ctrl
// Table walk sequencer: lookup/insert/update for log items, filtered scan
// for report items, result register toward the output channel.
// ----------------------------------------------------------------------------
module dact_ctrl import dact_pkg::*; #(
  parameter int MAX_USERS = MAX_USERS_DEF,
  parameter int AW        = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1,
  parameter int CW        = $clog2(MAX_USERS + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [USER_W-1:0]         in_user_id,
  input  logic                      in_denied,
  output logic                      out_valid,
  input  logic                      out_ready,
  output res_t                      out_res,
  input  logic [COUNT_W-1:0]        threshold,
  output logic                      mem_wr_en,
  output logic [AW-1:0]             mem_wr_addr,
  output logic [USER_W+COUNT_W-1:0] mem_wr_data,
  output logic                      mem_rd_en,
  output logic [AW-1:0]             mem_rd_addr,
  input  logic [USER_W+COUNT_W-1:0] mem_rd_data
);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_CMP, S_EMIT} state_t;

  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_USERS);

  state_t             state_r;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      stored_r;
  logic               act_r;
  logic [USER_W-1:0]  uid_r;
  logic               den_r;
  logic               pend_vld_r;
  logic [USER_W-1:0]  pend_user_r;
  logic [COUNT_W-1:0] pend_cnt_r;
  res_t               res_r;
  res_t               out_r;
  logic               out_valid_r;

  logic [USER_W-1:0]  rd_user;
  logic [COUNT_W-1:0] rd_cnt;
  logic [COUNT_W-1:0] new_cnt;
  logic [COUNT_W-1:0] ins_cnt;
  logic               scan_end;
  logic               is_rpt;
  logic               hit;
  logic               ins;
  logic               qual;
  logic               out_free;
  logic               out_load;
  logic [CW-1:0]      idx_inc;

  assign rd_user  = mem_rd_data[USER_W+COUNT_W-1:COUNT_W];
  assign rd_cnt   = mem_rd_data[COUNT_W-1:0];
  assign new_cnt  = (den_r && rd_cnt != {COUNT_W{1'b1}}) ? rd_cnt + COUNT_W'(1) : rd_cnt;
  assign ins_cnt  = COUNT_W'(den_r);
  assign scan_end = (idx_r == stored_r);
  assign is_rpt   = (act_r == ACT_REPORT);
  assign hit      = (state_r == S_CMP) && !is_rpt && (rd_user == uid_r);
  assign ins      = (state_r == S_RD) && scan_end && !is_rpt && (stored_r != FULL_CNT);
  assign qual     = (rd_cnt > threshold);
  assign out_free = !out_valid_r || out_ready;
  assign idx_inc  = idx_r + CW'(1);
  assign out_load = ((state_r == S_CMP) && is_rpt && qual && pend_vld_r && out_free) ||
                    ((state_r == S_EMIT) && out_free);

  assign mem_rd_en   = (state_r == S_RD) && !scan_end;
  assign mem_rd_addr = idx_r[AW-1:0];
  assign mem_wr_en   = hit || ins;
  assign mem_wr_addr = hit ? idx_r[AW-1:0] : stored_r[AW-1:0];
  assign mem_wr_data = hit ? {uid_r, new_cnt} : {uid_r, ins_cnt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      stored_r    <= '0;
      pend_vld_r  <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r      <= in_action;
            uid_r      <= in_user_id;
            den_r      <= in_denied;
            idx_r      <= '0;
            pend_vld_r <= 1'b0;
            state_r    <= S_RD;
          end
        end
        S_RD: begin
          if (scan_end) begin
            if (is_rpt) begin
              if (pend_vld_r) begin
                res_r <= '{1'b1, pend_user_r, pend_cnt_r, 1'b1, 1'b0, 1'b1};
              end else begin
                res_r <= '{1'b0, '0, '0, 1'b0, 1'b0, 1'b1};
              end
            end else if (stored_r == FULL_CNT) begin
              res_r <= '{1'b0, uid_r, '0, 1'b0, 1'b1, 1'b1};
            end else begin
              res_r    <= '{1'b1, uid_r, ins_cnt, (ins_cnt > threshold), 1'b0, 1'b1};
              stored_r <= stored_r + CW'(1);
            end
            state_r <= S_EMIT;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (is_rpt) begin
            if (!qual) begin
              idx_r   <= idx_inc;
              state_r <= S_RD;
            end else if (!pend_vld_r || out_free) begin
              if (pend_vld_r) begin
                out_r <= '{1'b1, pend_user_r, pend_cnt_r, 1'b1, 1'b0, 1'b0};
              end
              pend_vld_r  <= 1'b1;
              pend_user_r <= rd_user;
              pend_cnt_r  <= rd_cnt;
              idx_r       <= idx_inc;
              state_r     <= S_RD;
            end
          end else if (hit) begin
            res_r   <= '{1'b1, uid_r, new_cnt, (new_cnt > threshold), 1'b0, 1'b1};
            state_r <= S_EMIT;
          end else begin
            idx_r   <= idx_inc;
            state_r <= S_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

// ===== design/denied_access_counter_table.sv =====
// ----------------------------------------------------------------------------
// denied_access_counter_table
// Per-user denied-access counters with threshold report.
// ----------------------------------------------------------------------------
// One item is worked on at a time. The user table sits in a single RAM with a
// registered read port, and the sequencer visits each stored entry it needs
// in an address state (S_RD) and then a compare state (S_CMP). A log item
// walks the entries until it finds its user, or walks all of them before it
// inserts a new user or refuses one because the table is full; a report walks
// all stored entries, and both wait while the output side stalls.
// The input is ready again in the cycle after the last transfer of the
// previous item is loaded into the output register.
module denied_access_counter_table import dact_pkg::*; #(
  parameter int MAX_USERS = MAX_USERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [USER_W-1:0]     in_user_id,
  input  logic                  in_denied,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_entry_valid,
  output logic [USER_W-1:0]     out_user_out,
  output logic [COUNT_W-1:0]    out_denied_count,
  output logic                  out_over_threshold,
  output logic                  out_table_full,
  output logic                  out_last,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int AW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int MW = USER_W + COUNT_W;

  logic [COUNT_W-1:0] threshold;
  res_t               res;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [MW-1:0]      wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [MW-1:0]      rd_data;

  dact_apb u_apb (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .threshold (threshold)
  );

  dact_ctrl #(
    .MAX_USERS (MAX_USERS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_user_id  (in_user_id),
    .in_denied   (in_denied),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res     (res),
    .threshold   (threshold),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_data (wr_data),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_rd_data (rd_data)
  );

  dact_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_USERS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_entry_valid    = res.entry_valid;
  assign out_user_out       = res.user_out;
  assign out_denied_count   = res.denied_count;
  assign out_over_threshold = res.over_threshold;
  assign out_table_full     = res.table_full;
  assign out_last           = res.last;

endmodule

// ===== design/dact_chk.sv =====
// ----------------------------------------------------------------------------
// dact_chk
// Port-level checks of the denied-access counter table, bound to the top.
// ----------------------------------------------------------------------------
module dact_chk import dact_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_entry_valid,
  input logic [COUNT_W-1:0]    out_denied_count,
  input logic                  out_over_threshold,
  input logic                  out_table_full,
  input logic                  out_last,
  input logic                  cfg_psel,
  input logic                  cfg_penable,
  input logic                  cfg_pwrite,
  input logic [CFG_ADDR_W-1:0] cfg_paddr,
  input logic [CFG_DATA_W-1:0] cfg_pwdata,
  input logic [CFG_DATA_W-1:0] cfg_prdata
);

  // one item in flight: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |->
      out_last && !out_entry_valid && !out_over_threshold && out_denied_count == '0)
    else $error("malformed table-full result");

  a_thresh_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_DENIED_THRESHOLD |=>
      cfg_paddr[2] != REG_DENIED_THRESHOLD ||
      cfg_prdata[COUNT_W-1:0] == $past(cfg_pwdata[COUNT_W-1:0]))
    else $error("threshold readback mismatch");

endmodule

bind denied_access_counter_table dact_chk u_dact_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_entry_valid    (out_entry_valid),
  .out_denied_count   (out_denied_count),
  .out_over_threshold (out_over_threshold),
  .out_table_full     (out_table_full),
  .out_last           (out_last),
  .cfg_psel           (cfg_psel),
  .cfg_penable        (cfg_penable),
  .cfg_pwrite         (cfg_pwrite),
  .cfg_paddr          (cfg_paddr),
  .cfg_pwdata         (cfg_pwdata),
  .cfg_prdata         (cfg_prdata)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the denied-access counter table. A shadow copy of
// the user table predicts every result at the input transfer; results are
// compared in order. Covers empty and full tables, threshold extremes,
// random traffic under input and output idling, and a long output hold-off
// that backs up the input.
// ----------------------------------------------------------------------------
module tb import dact_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int   STALL_LIMIT = 5000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_action;
  logic [USER_W-1:0]     in_user_id;
  logic                  in_denied;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_entry_valid;
  logic [USER_W-1:0]     out_user_out;
  logic [COUNT_W-1:0]    out_denied_count;
  logic                  out_over_threshold;
  logic                  out_table_full;
  logic                  out_last;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  denied_access_counter_table uut (.*);

  // shadow state
  logic [USER_W-1:0]  user_id_tab [MAX_USERS_DEF];
  logic [COUNT_W-1:0] denied_tab  [MAX_USERS_DEF];
  int                 n_users = 0;
  logic [COUNT_W-1:0] threshold_shadow = THRESH_RESET;
  res_t               due_results [$];

  int idle_in_pct   = 0;
  int stall_out_pct = 0;
  int hold_off      = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void tally_item(logic act, logic [USER_W-1:0] uid, logic den);
    res_t r;
    int   slot;
    int   hits;
    slot = -1;
    hits = 0;
    if (act == ACT_REPORT) begin
      for (int i = 0; i < n_users; i++) begin
        if (denied_tab[i] > threshold_shadow) begin
          r = '{1'b1, user_id_tab[i], denied_tab[i], 1'b1, 1'b0, 1'b0};
          due_results.push_back(r);
          hits++;
        end
      end
      if (hits == 0) begin
        r = '{1'b0, '0, '0, 1'b0, 1'b0, 1'b1};
      end else begin
        r = due_results.pop_back();
        r.last = 1'b1;
      end
      due_results.push_back(r);
      return;
    end
    for (int i = 0; i < n_users; i++) begin
      if (user_id_tab[i] == uid) begin
        slot = i;
        break;
      end
    end
    if (slot < 0) begin
      if (n_users >= MAX_USERS_DEF) begin
        r = '{1'b0, uid, '0, 1'b0, 1'b1, 1'b1};
        due_results.push_back(r);
        return;
      end
      slot = n_users;
      user_id_tab[slot] = uid;
      denied_tab[slot] = '0;
      n_users++;
    end
    if (den && denied_tab[slot] != '1) denied_tab[slot] = denied_tab[slot] + COUNT_W'(1);
    r = '{1'b1, uid, denied_tab[slot], denied_tab[slot] > threshold_shadow, 1'b0, 1'b1};
    due_results.push_back(r);
  endfunction

  function automatic void flag_mismatch(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: exp v=%0b user=%h cnt=%0d over=%0b full=%0b last=%0b",
               $time, what, want.entry_valid, want.user_out, want.denied_count,
               want.over_threshold, want.table_full, want.last);
      $display("%0t %s: got v=%0b user=%h cnt=%0d over=%0b full=%0b last=%0b",
               $time, what, got.entry_valid, got.user_out, got.denied_count,
               got.over_threshold, got.table_full, got.last);
    end
  endfunction

  // result check and prediction, both on the sampled handshake
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_entry_valid, out_user_out, out_denied_count, out_over_threshold,
                out_table_full, out_last};
        if (due_results.size() == 0) begin
          flag_mismatch("unexpected transfer", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got !== want) flag_mismatch("result mismatch", want, got);
        end
      end
      if (in_valid && in_ready) tally_item(in_action, in_user_id, in_denied);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off = hold_off - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_out_pct);
      end
    end
  end

  task automatic send_item(input logic act, input logic [USER_W-1:0] uid, input logic den);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_user_id <= uid;
    in_denied  <= den;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic write_threshold(input logic [COUNT_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_DENIED_THRESHOLD, 2'b00};
    cfg_pwdata  <= {16'($urandom), v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    threshold_shadow = v;
  endtask

  task automatic test_first_users;
    send_item(ACT_REPORT, 32'hFFFF_FFFF, 1'b1);   // empty table
    send_item(ACT_LOG, 32'h0000_0000, 1'b0);
    send_item(ACT_LOG, 32'hFFFF_FFFF, 1'b1);
    repeat (8) send_item(ACT_LOG, 32'h0000_0000, 1'b1);
    send_item(ACT_REPORT, 32'h0000_0000, 1'b0);
    send_item(ACT_LOG, 32'hFFFF_FFFF, 1'b0);
    send_item(ACT_LOG, 32'hA5A5_5A5A, 1'b1);
    drain();
  endtask

  task automatic test_threshold_edges;
    write_threshold(16'd0);
    send_item(ACT_REPORT, 32'h0, 1'b0);
    drain();
    write_threshold(16'd8);
    send_item(ACT_REPORT, 32'h0, 1'b0);
    send_item(ACT_LOG, 32'hA5A5_5A5A, 1'b0);
    drain();
    write_threshold(16'hFFFF);
    send_item(ACT_REPORT, 32'h0, 1'b0);
    drain();
    write_threshold(THRESH_RESET);
  endtask

  task automatic test_table_full;
    while (n_users < MAX_USERS_DEF) send_item(ACT_LOG, $urandom, 1'($urandom));
    send_item(ACT_LOG, $urandom, 1'b1);
    send_item(ACT_LOG, $urandom, 1'b0);
    send_item(ACT_LOG, user_id_tab[MAX_USERS_DEF-1], 1'b1);
    send_item(ACT_REPORT, $urandom, 1'($urandom));
    drain();
  endtask

  task automatic run_random_phase(input int in_pct, input int out_pct, input int n,
                                  input logic [COUNT_W-1:0] thr);
    int                pick;
    logic [USER_W-1:0] uid;
    idle_in_pct   = in_pct;
    stall_out_pct = out_pct;
    write_threshold(thr);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_item(ACT_REPORT, $urandom, 1'($urandom));
      end else begin
        if (pick < 35) uid = $urandom;
        else uid = user_id_tab[$urandom_range(n_users - 1)];
        send_item(ACT_LOG, uid, $urandom_range(99) < 70);
      end
    end
    drain();
  endtask

  task automatic test_backpressure;
    idle_in_pct   = 0;
    stall_out_pct = 0;
    hold_off      = 400;
    repeat (24) begin
      if ($urandom_range(3) == 0) send_item(ACT_REPORT, $urandom, 1'($urandom));
      else send_item(ACT_LOG, user_id_tab[$urandom_range(n_users - 1)], 1'($urandom));
    end
    drain();
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_action   <= ACT_LOG;
    in_user_id  <= '0;
    in_denied   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_users();
    test_threshold_edges();
    run_random_phase(0, 0, 70, 16'd2);
    test_table_full();
    run_random_phase(78, 0, 70, 16'($urandom_range(10)));
    run_random_phase(0, 78, 70, 16'd0);
    run_random_phase(31, 31, 70, 16'd4);
    test_backpressure();

    repeat (2 * MAX_USERS_DEF + 10) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
